@@ src/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, operation codes, constants and helper functions of the
// complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   // default configuration
   localparam int DATA_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int ANGLE_ITERS_DEF = 24;

   // fixed field and datapath widths
   localparam int FIELD_W    = 32;
   localparam int KIND_W     = 4;
   localparam int EXP_W      = 8;
   localparam int WIDE_W     = 128;
   localparam int OPX_W      = 64;
   localparam int Z_W        = 34;
   localparam int ATAN_IDX_W = 6;
   localparam int ROOT_W     = 33;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_ADD   = 4'd0;
   localparam logic [KIND_W-1:0] KIND_SUB   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_MUL   = 4'd2;
   localparam logic [KIND_W-1:0] KIND_CONJ  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_SCALE = 4'd4;
   localparam logic [KIND_W-1:0] KIND_POWER = 4'd5;
   localparam logic [KIND_W-1:0] KIND_MODSQ = 4'd6;
   localparam logic [KIND_W-1:0] KIND_MOD   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_ARG   = 4'd8;

   // angles in Q30
   localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   // one product request to the shared multiplier
   typedef struct packed {
      logic                       start;
      logic                       clear;
      logic                       sub;
      logic signed [OPX_W-1:0]    x;
      logic signed [FIELD_W-1:0]  y;
   } mul_cmd_type;

   // multiplier status back to the sequencer
   typedef struct packed {
      logic                       done;
      logic signed [WIDE_W-1:0]   acc;
   } mul_stat_type;

   // saturated value with its overflow flag
   typedef struct packed {
      logic signed [OPX_W-1:0] val;
      logic                    ov;
   } sat_type;

   // round half up by sh bits, then saturate to dw signed bits
   function automatic sat_type sat_round(logic signed [WIDE_W-1:0] v, int sh, int dw);
      logic signed [WIDE_W-1:0] t;
      logic signed [WIDE_W-1:0] mx;
      logic signed [WIDE_W-1:0] mn;
      sat_type r;
      t = v;
      if (sh > 0) begin
         t = t + (WIDE_W'(1) <<< (sh - 1));
      end
      t  = t >>> sh;
      mx = (WIDE_W'(1) <<< (dw - 1)) - WIDE_W'(1);
      mn = -mx - WIDE_W'(1);
      if (t > mx) begin
         r.val = mx[OPX_W-1:0];
         r.ov  = 1'b1;
      end else if (t < mn) begin
         r.val = mn[OPX_W-1:0];
         r.ov  = 1'b1;
      end else begin
         r.val = t[OPX_W-1:0];
         r.ov  = 1'b0;
      end
      return r;
   endfunction

   // arctangent of 2^-i in Q30
   function automatic logic signed [Z_W-1:0] atan_q30(logic [ATAN_IDX_W-1:0] i);
      logic signed [Z_W-1:0] r;
      case (i)
         6'd0: r = 34'sh03243F6A8;
         6'd1: r = 34'sh01DAC6705;
         6'd2: r = 34'sh00FADBAFC;
         6'd3: r = 34'sh007F56EA6;
         6'd4: r = 34'sh003FEAB76;
         6'd5: r = 34'sh001FFD55B;
         6'd6: r = 34'sh000FFFAAA;
         6'd7: r = 34'sh0007FFF55;
         6'd8: r = 34'sh0003FFFEA;
         6'd9: r = 34'sh0001FFFFD;
         default: begin
            if (i < 6'd30) begin
               r = (Z_W'(1) << (6'd30 - i)) - Z_W'(1);
            end else begin
               r = '0;
            end
         end
      endcase
      return r;
   endfunction

endpackage

@@ src/cau_ifs.sv @@
// ----------------------------------------------------------------------------
// cau_ifs
// Valid/ready channels of the complex arithmetic unit: request and response.
// ----------------------------------------------------------------------------
interface cau_req_if;
   logic                                valid;
   logic                                ready;
   logic [cau_pkg::KIND_W-1:0]          kind;
   logic signed [cau_pkg::FIELD_W-1:0]  a_re;
   logic signed [cau_pkg::FIELD_W-1:0]  a_im;
   logic signed [cau_pkg::FIELD_W-1:0]  b_re;
   logic signed [cau_pkg::FIELD_W-1:0]  b_im;
   logic signed [cau_pkg::FIELD_W-1:0]  factor;
   logic signed [cau_pkg::EXP_W-1:0]    exponent;

   modport source(output valid, kind, a_re, a_im, b_re, b_im, factor, exponent,
                  input ready);
   modport sink(input valid, kind, a_re, a_im, b_re, b_im, factor, exponent,
                output ready);
endinterface

interface cau_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cau_pkg::FIELD_W-1:0]  res_re;
   logic signed [cau_pkg::FIELD_W-1:0]  res_im;
   logic                                overflow;

   modport source(output valid, res_re, res_im, overflow, input ready);
   modport sink(input valid, res_re, res_im, overflow, output ready);
endinterface

@@ src/cau_mul.sv @@
// ----------------------------------------------------------------------------
// cau_mul
// Shared signed multiply-accumulate unit: one 32x32 partial product per
// cycle over the 32-bit limbs of x, accumulated exactly into a wide sum.
// ----------------------------------------------------------------------------
module cau_mul #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cau_pkg::mul_cmd_type  cmd,
   output cau_pkg::mul_stat_type stat
);
   localparam int LIMBS = (DATA_WIDTH + 31) / 32;
   localparam int MAG_W = LIMBS * 32;
   localparam int CNT_W = $clog2(LIMBS + 1);

   logic [MAG_W-1:0]                    xm_ff;
   logic [31:0]                         ym_ff;
   logic                                neg_ff;
   logic [CNT_W-1:0]                    left_ff;
   logic [CNT_W-1:0]                    k_ff;
   logic [CNT_W-1:0]                    pk_ff;
   logic [63:0]                         prod_ff;
   logic                                prod_v_ff;
   logic                                prod_last_ff;
   logic                                done_ff;
   logic signed [cau_pkg::WIDE_W-1:0]   acc_ff;

   logic [cau_pkg::OPX_W-1:0]           x_mag;
   logic [31:0]                         y_mag;
   logic [cau_pkg::WIDE_W-1:0]          term;

   // operand magnitudes and weighted partial product
   always_comb begin
      x_mag = cmd.x[cau_pkg::OPX_W-1] ? cau_pkg::OPX_W'(-cmd.x) : cau_pkg::OPX_W'(cmd.x);
      y_mag = cmd.y[31] ? 32'(-cmd.y) : 32'(cmd.y);
      term  = cau_pkg::WIDE_W'(prod_ff) << {pk_ff, 5'd0};
   end

   // limb sequencing control
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         prod_v_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         if (cmd.start) begin
            left_ff <= CNT_W'(LIMBS);
         end else if (left_ff != '0) begin
            left_ff <= left_ff - CNT_W'(1);
         end
         prod_v_ff <= (left_ff != '0) && !cmd.start;
         done_ff   <= prod_v_ff && prod_last_ff;
      end
   end

   // operands, partial product and accumulator
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         xm_ff  <= x_mag[MAG_W-1:0];
         ym_ff  <= y_mag;
         neg_ff <= cmd.x[cau_pkg::OPX_W-1] ^ cmd.y[31] ^ cmd.sub;
         k_ff   <= '0;
      end else if (left_ff != '0) begin
         prod_ff      <= xm_ff[31:0] * ym_ff;
         xm_ff        <= xm_ff >> 32;
         pk_ff        <= k_ff;
         k_ff         <= k_ff + CNT_W'(1);
         prod_last_ff <= (left_ff == CNT_W'(1));
      end
      if (cmd.start && cmd.clear) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= neg_ff ? acc_ff - term : acc_ff + term;
      end
   end

   assign stat.done = done_ff;
   assign stat.acc  = acc_ff;

endmodule

@@ src/cau_sqrt.sv @@
// ----------------------------------------------------------------------------
// cau_sqrt
// Restoring square root, two radicand bits per step, with a final step
// that rounds the root to nearest.
// ----------------------------------------------------------------------------
module cau_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [63:0]                 radicand,
   output logic                        done,
   output logic [cau_pkg::ROOT_W-1:0]  root
);
   localparam int STEPS = 32;

   logic [63:0]                 rad_ff;
   logic [33:0]                 rem_ff;
   logic [31:0]                 root_ff;
   logic [5:0]                  cnt_ff;
   logic                        busy_ff;
   logic                        fin_ff;
   logic                        done_ff;
   logic [cau_pkg::ROOT_W-1:0]  root_out_ff;

   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic        ge;

   // one trial subtraction
   always_comb begin
      rem_sh = {rem_ff, rad_ff[63:62]};
      trial  = {2'b00, root_ff, 2'b01};
      ge     = rem_sh >= trial;
   end

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         fin_ff  <= busy_ff && (cnt_ff == 6'd1);
         done_ff <= fin_ff;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == 6'd1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // remainder and root
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= 6'(STEPS);
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= ge ? 34'(rem_sh - trial) : 34'(rem_sh);
         root_ff <= {root_ff[30:0], ge};
         cnt_ff  <= cnt_ff - 6'd1;
      end
      if (fin_ff) begin
         root_out_ff <= {1'b0, root_ff} +
                        cau_pkg::ROOT_W'(rem_ff > {2'b00, root_ff});
      end
   end

   assign done = done_ff;
   assign root = root_out_ff;

endmodule

@@ src/cau_cordic.sv @@
// ----------------------------------------------------------------------------
// cau_cordic
// CORDIC vectoring for the argument: quadrant fold, then one micro-rotation
// per cycle with a Q30 angle accumulator.
// ----------------------------------------------------------------------------
module cau_cordic #(
   parameter int ANGLE_ITERS = cau_pkg::ANGLE_ITERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [cau_pkg::FIELD_W-1:0]  x,
   input  logic signed [cau_pkg::FIELD_W-1:0]  y,
   output logic                                done,
   output logic signed [cau_pkg::Z_W-1:0]      z
);
   localparam int IT_W = $clog2(ANGLE_ITERS);
   localparam int XY_W = 36;

   logic signed [XY_W-1:0]         x_ff;
   logic signed [XY_W-1:0]         y_ff;
   logic signed [cau_pkg::Z_W-1:0] z_ff;
   logic [IT_W-1:0]                it_ff;
   logic                           busy_ff;
   logic                           done_ff;

   logic signed [XY_W-1:0]         xs;
   logic signed [XY_W-1:0]         ys;
   logic signed [XY_W-1:0]         dx;
   logic signed [XY_W-1:0]         dy;
   logic signed [cau_pkg::Z_W-1:0] at;
   logic                           last;

   // micro-rotation terms
   always_comb begin
      xs   = XY_W'(x);
      ys   = XY_W'(y);
      dx   = y_ff >>> it_ff;
      dy   = x_ff >>> it_ff;
      at   = cau_pkg::atan_q30(cau_pkg::ATAN_IDX_W'(it_ff));
      last = (it_ff == IT_W'(ANGLE_ITERS - 1));
   end

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (start && (y == '0)) || (busy_ff && last);
         if (start) begin
            busy_ff <= (y != '0);
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // vector and angle
   always_ff @(posedge clock) begin
      if (start) begin
         it_ff <= '0;
         if (y == '0) begin
            z_ff <= x[cau_pkg::FIELD_W-1] ? cau_pkg::PI_Q30 : '0;
         end else if (x[cau_pkg::FIELD_W-1] && !y[cau_pkg::FIELD_W-1]) begin
            x_ff <= ys;
            y_ff <= -xs;
            z_ff <= cau_pkg::HALF_PI_Q30;
         end else if (x[cau_pkg::FIELD_W-1]) begin
            x_ff <= -ys;
            y_ff <= xs;
            z_ff <= -cau_pkg::HALF_PI_Q30;
         end else begin
            x_ff <= xs;
            y_ff <= ys;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         it_ff <= it_ff + IT_W'(1);
         if (!y_ff[XY_W-1]) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end
      end
   end

   assign done = done_ff;
   assign z    = z_ff;

endmodule

@@ src/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex-number ALU in signed fixed point: add, subtract, multiply,
// conjugate, scale, integer power, modulus squared, modulus and argument.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   req_port | in        | kind, a_re, a_im, b_re, b_im, factor, exponent
//   rsp_port | out       | res_re, res_im, overflow
//
// Add, subtract, conjugate and unused codes go from setup straight to done.
// One real product runs over the LIMBS 32-bit limbs in the shared multiplier
// (LIMBS = 1 for DATA_WIDTH up to 32, 2 up to 64); a complex multiply is four
// of them, and power runs exponent complex multiplies in series.
// Modulus takes two products and then the square root; argument runs the
// CORDIC vectoring loop.
// Requests are taken one at a time; a finished response waits in the output
// register while the next request is accepted. Synchronous reset, no sweep.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH  = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS   = cau_pkg::FRAC_BITS_DEF,
   parameter int ANGLE_ITERS = cau_pkg::ANGLE_ITERS_DEF
) (
   input logic          clock,
   input logic          reset,
   cau_req_if.sink      req_port,
   cau_rsp_if.source    rsp_port
);
   localparam int FW = cau_pkg::FIELD_W;
   localparam int XW = cau_pkg::OPX_W;
   localparam int WW = cau_pkg::WIDE_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_SQRT   = 3'd3;
   localparam logic [2:0] ST_CORDIC = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic [cau_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic signed [FW-1:0]         ar_ff, ar_in;
   logic signed [FW-1:0]         ai_ff, ai_in;
   logic signed [FW-1:0]         fa_ff, fa_in;
   logic signed [cau_pkg::EXP_W-1:0] exp_ff, exp_in;
   logic signed [XW-1:0]         xr_ff, xr_in;
   logic signed [XW-1:0]         xi_ff, xi_in;
   logic [6:0]                   cnt_ff, cnt_in;
   logic [1:0]                   step_ff, step_in;
   logic                         issued_ff, issued_in;
   logic signed [XW-1:0]         re_tmp_ff, re_tmp_in;
   logic signed [XW-1:0]         res_re_ff, res_re_in;
   logic signed [XW-1:0]         res_im_ff, res_im_in;
   logic                         ov_ff, ov_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [FW-1:0]         rsp_re_ff, rsp_re_in;
   logic signed [FW-1:0]         rsp_im_ff, rsp_im_in;
   logic                         rsp_ov_ff, rsp_ov_in;

   cau_pkg::mul_cmd_type         mul_cmd;
   cau_pkg::mul_stat_type        mul_stat;
   logic                         sqrt_start;
   logic                         sqrt_done;
   logic [cau_pkg::ROOT_W-1:0]   sq_root;
   logic                         cordic_start;
   logic                         cordic_done;
   logic signed [cau_pkg::Z_W-1:0] cz;

   cau_pkg::sat_type             simple_re;
   cau_pkg::sat_type             simple_im;
   cau_pkg::sat_type             acc_s;
   cau_pkg::sat_type             one_s;
   cau_pkg::sat_type             sqrt_s;
   cau_pkg::sat_type             arg_s;

   // shared units
   cau_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .stat  (mul_stat)
   );

   cau_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (mul_stat.acc[63:0]),
      .done     (sqrt_done),
      .root     (sq_root)
   );

   cau_cordic #(.ANGLE_ITERS(ANGLE_ITERS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x     (ar_ff),
      .y     (ai_ff),
      .done  (cordic_done),
      .z     (cz)
   );

   // rounding and saturation of the candidate results
   always_comb begin
      case (kind_ff)
         cau_pkg::KIND_ADD: begin
            simple_re = cau_pkg::sat_round(WW'(ar_ff) + WW'(xr_ff), 0, DATA_WIDTH);
            simple_im = cau_pkg::sat_round(WW'(ai_ff) + WW'(xi_ff), 0, DATA_WIDTH);
         end
         cau_pkg::KIND_SUB: begin
            simple_re = cau_pkg::sat_round(WW'(ar_ff) - WW'(xr_ff), 0, DATA_WIDTH);
            simple_im = cau_pkg::sat_round(WW'(ai_ff) - WW'(xi_ff), 0, DATA_WIDTH);
         end
         default: begin
            simple_re = cau_pkg::sat_round(WW'(ar_ff), 0, DATA_WIDTH);
            simple_im = cau_pkg::sat_round(-WW'(ai_ff), 0, DATA_WIDTH);
         end
      endcase
      acc_s  = cau_pkg::sat_round(mul_stat.acc, FRAC_BITS, DATA_WIDTH);
      one_s  = cau_pkg::sat_round(WW'(1) << FRAC_BITS, 0, DATA_WIDTH);
      sqrt_s = cau_pkg::sat_round(WW'(sq_root), 0, DATA_WIDTH);
      arg_s  = cau_pkg::sat_round(WW'(cz), 30 - FRAC_BITS, DATA_WIDTH);
   end

   // product selection per operation and step
   always_comb begin
      mul_cmd.start = (state_ff == ST_MUL) && !issued_ff;
      mul_cmd.clear = !step_ff[0];
      mul_cmd.sub   = 1'b0;
      mul_cmd.x     = '0;
      mul_cmd.y     = '0;
      case (kind_ff)
         cau_pkg::KIND_MUL, cau_pkg::KIND_POWER: begin
            case (step_ff)
               2'd0: begin
                  mul_cmd.x = xr_ff;
                  mul_cmd.y = ar_ff;
               end
               2'd1: begin
                  mul_cmd.x   = xi_ff;
                  mul_cmd.y   = ai_ff;
                  mul_cmd.sub = 1'b1;
               end
               2'd2: begin
                  mul_cmd.x = xr_ff;
                  mul_cmd.y = ai_ff;
               end
               default: begin
                  mul_cmd.x = xi_ff;
                  mul_cmd.y = ar_ff;
               end
            endcase
         end
         cau_pkg::KIND_SCALE: begin
            case (step_ff)
               2'd0: begin
                  mul_cmd.x = XW'(ar_ff);
                  mul_cmd.y = fa_ff;
               end
               2'd2: begin
                  mul_cmd.x = XW'(ai_ff);
                  mul_cmd.y = fa_ff;
               end
               default: begin
                  mul_cmd.x = '0;
               end
            endcase
         end
         default: begin
            case (step_ff)
               2'd0: begin
                  mul_cmd.x = XW'(ar_ff);
                  mul_cmd.y = ar_ff;
               end
               2'd1: begin
                  mul_cmd.x = XW'(ai_ff);
                  mul_cmd.y = ai_ff;
               end
               default: begin
                  mul_cmd.x = '0;
               end
            endcase
         end
      endcase
   end

   // unit start pulses
   assign sqrt_start = (state_ff == ST_MUL) && issued_ff && mul_stat.done &&
                       (step_ff == 2'd1) && (kind_ff == cau_pkg::KIND_MOD);
   assign cordic_start = (state_ff == ST_SETUP) && (kind_ff == cau_pkg::KIND_ARG);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      ar_in        = ar_ff;
      ai_in        = ai_ff;
      fa_in        = fa_ff;
      exp_in       = exp_ff;
      xr_in        = xr_ff;
      xi_in        = xi_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      issued_in    = issued_ff;
      re_tmp_in    = re_tmp_ff;
      res_re_in    = res_re_ff;
      res_im_in    = res_im_ff;
      ov_in        = ov_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_ov_in    = rsp_ov_ff;

      // response taken
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               kind_in   = req_port.kind;
               ar_in     = req_port.a_re;
               ai_in     = req_port.a_im;
               fa_in     = req_port.factor;
               exp_in    = req_port.exponent;
               xr_in     = XW'(req_port.b_re);
               xi_in     = XW'(req_port.b_im);
               ov_in     = 1'b0;
               step_in   = 2'd0;
               issued_in = 1'b0;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            case (kind_ff)
               cau_pkg::KIND_ADD, cau_pkg::KIND_SUB, cau_pkg::KIND_CONJ: begin
                  res_re_in = simple_re.val;
                  res_im_in = simple_im.val;
                  ov_in     = simple_re.ov | simple_im.ov;
                  state_in  = ST_DONE;
               end
               cau_pkg::KIND_MUL, cau_pkg::KIND_SCALE, cau_pkg::KIND_MODSQ,
               cau_pkg::KIND_MOD: begin
                  state_in = ST_MUL;
               end
               cau_pkg::KIND_POWER: begin
                  xr_in     = one_s.val;
                  xi_in     = '0;
                  ov_in     = one_s.ov;
                  res_re_in = one_s.val;
                  res_im_in = '0;
                  if (exp_ff > 0) begin
                     cnt_in   = exp_ff[6:0];
                     state_in = ST_MUL;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               cau_pkg::KIND_ARG: begin
                  state_in = ST_CORDIC;
               end
               default: begin
                  res_re_in = '0;
                  res_im_in = '0;
                  ov_in     = 1'b0;
                  state_in  = ST_DONE;
               end
            endcase
         end
         ST_MUL: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (mul_stat.done) begin
               issued_in = 1'b0;
               case (step_ff)
                  2'd1: begin
                     if (kind_ff == cau_pkg::KIND_MOD) begin
                        state_in = ST_SQRT;
                     end else if (kind_ff == cau_pkg::KIND_MODSQ) begin
                        res_re_in = acc_s.val;
                        res_im_in = '0;
                        ov_in     = ov_ff | acc_s.ov;
                        state_in  = ST_DONE;
                     end else begin
                        re_tmp_in = acc_s.val;
                        ov_in     = ov_ff | acc_s.ov;
                        step_in   = 2'd2;
                     end
                  end
                  2'd3: begin
                     ov_in   = ov_ff | acc_s.ov;
                     step_in = 2'd0;
                     if ((kind_ff == cau_pkg::KIND_POWER) && (cnt_ff != 7'd1)) begin
                        xr_in  = re_tmp_ff;
                        xi_in  = acc_s.val;
                        cnt_in = cnt_ff - 7'd1;
                     end else begin
                        res_re_in = re_tmp_ff;
                        res_im_in = acc_s.val;
                        state_in  = ST_DONE;
                     end
                  end
                  default: begin
                     step_in = step_ff + 2'd1;
                  end
               endcase
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               res_re_in = sqrt_s.val;
               res_im_in = '0;
               ov_in     = ov_ff | sqrt_s.ov;
               state_in  = ST_DONE;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               res_re_in = arg_s.val;
               res_im_in = '0;
               ov_in     = ov_ff | arg_s.ov;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_re_in    = res_re_ff[FW-1:0];
               rsp_im_in    = res_im_ff[FW-1:0];
               rsp_ov_in    = ov_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operand and result registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      ar_ff     <= ar_in;
      ai_ff     <= ai_in;
      fa_ff     <= fa_in;
      exp_ff    <= exp_in;
      xr_ff     <= xr_in;
      xi_ff     <= xi_in;
      cnt_ff    <= cnt_in;
      step_ff   <= step_in;
      re_tmp_ff <= re_tmp_in;
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      ov_ff     <= ov_in;
      rsp_re_ff <= rsp_re_in;
      rsp_im_ff <= rsp_im_in;
      rsp_ov_ff <= rsp_ov_in;
   end

   // channel outputs
   assign req_port.ready    = (state_ff == ST_IDLE);
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.res_re   = rsp_re_ff;
   assign rsp_port.res_im   = rsp_im_ff;
   assign rsp_port.overflow = rsp_ov_ff;

endmodule

@@ src/cau_checker.sv @@
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [cau_pkg::FIELD_W-1:0] rsp_re,
   input logic signed [cau_pkg::FIELD_W-1:0] rsp_im,
   input logic                              rsp_ov
);
   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_re) && $stable(rsp_im) && $stable(rsp_ov))
      else $error("response payload changed while stalled");

   // one transaction in flight at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no response sooner than the setup cycle allows
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early");

   // clean state after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_re    (rsp_port.res_re),
   .rsp_im    (rsp_port.res_im),
   .rsp_ov    (rsp_port.overflow)
);
